/* rtl/core/chtbl_pkg.sv */
// ----------------------------------------------------------------------------
// chtbl_pkg
// Shared types and constants of the chained hash table: field widths,
// opcodes, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package chtbl_pkg;

    // field widths of the request and result items
    localparam int ID_W      = 16;
    localparam int NAME_W    = 8;
    localparam int ORD_W     = 16;
    localparam int SIZE_W    = 5;
    localparam int BKT_OUT_W = 4;
    localparam int STAT_W    = 2;

    // defaults of the top-level parameters
    localparam int MAX_BUCKETS_DEF = 16;
    localparam int POOL_DEPTH_DEF  = 32;

    // table size after reset
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd10;

    // request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RECORD   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_INS_RD,
        S_INS_WR1,
        S_INS_WR2,
        S_INS_OUT,
        S_DMP_HEAD,
        S_DMP_CHK,
        S_DMP_REC,
        S_DMP_EMIT
    } t_state;

endpackage

/* rtl/core/chained_hash_table_insert_dump_top.sv */
// ----------------------------------------------------------------------------
// chained_hash_table_insert_dump_top
// Hash table with separate chaining over a fixed record pool: insert and
// dump requests, one result register towards the receiver.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (i_in_valid / o_in_stall) takes one insert or dump
//   request at a time; o_in_stall is high while a request is being worked.
//   Results leave through a single output register (o_out_valid /
//   i_out_stall); a pending result does not block the next request.
//   Insert: the bucket is found by a bit-serial remainder unit, one id bit
//   per cycle, then a table read and one or two table writes, or none when
//   the pool is full and the record is dropped; a single result follows.
//   The block goes back to idle as soon as that result is loaded.
//   Dump: buckets are walked in order through the registered-read head,
//   link and record memories: per bucket a head read, then a check; per
//   record a read, then an emit. The final result carries o_last.
//   A stalled receiver holds the result; the walk waits until the output
//   register frees. Reset empties every bucket, clears the fill count and
//   sets the table size to 10; no clearing pass is needed. Write the table
//   size only while the block is idle.
// ----------------------------------------------------------------------------
module chained_hash_table_insert_dump_top #(
    parameter int MAX_BUCKETS = chtbl_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_DEPTH  = chtbl_pkg::POOL_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [chtbl_pkg::SIZE_W-1:0]       i_cfg_data,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic [chtbl_pkg::ID_W-1:0]         i_rec_id,
    input  logic [chtbl_pkg::NAME_W-1:0]       i_rec_name,
    input  logic [chtbl_pkg::ORD_W-1:0]        i_rec_order,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [chtbl_pkg::STAT_W-1:0]       o_status,
    output logic [chtbl_pkg::BKT_OUT_W-1:0]    o_bucket,
    output logic [chtbl_pkg::ID_W-1:0]         o_out_id,
    output logic [chtbl_pkg::NAME_W-1:0]       o_out_name,
    output logic [chtbl_pkg::ORD_W-1:0]        o_out_order,
    output logic                               o_last
);

    localparam int BW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int PW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW   = $clog2(POOL_DEPTH + 1);
    localparam int SW   = chtbl_pkg::SIZE_W;
    localparam int IW   = chtbl_pkg::ID_W;
    localparam int NW   = chtbl_pkg::NAME_W;
    localparam int OW   = chtbl_pkg::ORD_W;
    localparam int CNTW = $clog2(IW);
    localparam int RECW = IW + NW + OW;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    chtbl_pkg::t_state          r_state, n_state;
    logic [SW-1:0]              r_table_size;
    logic [MAX_BUCKETS-1:0]     r_head_valid;
    logic [CW-1:0]              r_fill;
    logic [BW-1:0]              r_bkt;
    logic [PW-1:0]              r_cur;
    logic [SW-1:0]              r_rem;
    logic [CNTW-1:0]            r_cnt;
    logic [IW-1:0]              r_shift;
    logic                       r_drop;
    logic [IW-1:0]              r_id;
    logic [NW-1:0]              r_name;
    logic [OW-1:0]              r_order;

    // memories, all with registered read
    logic [PW-1:0]              head_mem [MAX_BUCKETS];
    logic [PW-1:0]              tail_mem [MAX_BUCKETS];
    logic [PW:0]                link_mem [POOL_DEPTH];
    logic [RECW-1:0]            rec_mem  [POOL_DEPTH];
    logic [PW-1:0]              r_head_rd;
    logic [PW-1:0]              r_tail_rd;
    logic [PW:0]                r_link_rd;
    logic [RECW-1:0]            r_rec_rd;

    // result register
    logic                       r_out_valid;
    logic [chtbl_pkg::STAT_W-1:0] r_status;
    logic [BW-1:0]              r_out_bkt;
    logic [IW-1:0]              r_out_id;
    logic [NW-1:0]              r_out_name;
    logic [OW-1:0]              r_out_order;
    logic                       r_last;

    // ------------------------------------------------------------------
    // shared signals
    // ------------------------------------------------------------------
    logic [SW-1:0]  eff_size;
    logic           in_acc;
    logic           out_free;
    logic           last_bkt;
    logic           head_hit;
    logic [PW-1:0]  fill_idx;

    // remainder unit
    logic           div_bit;
    logic [SW:0]    div_part;
    logic           div_ge;
    logic [SW-1:0]  div_rem;
    logic           div_done;

    // sequencer controls
    logic                         out_load;
    logic [chtbl_pkg::STAT_W-1:0] out_status;
    logic                         out_last;
    logic                         out_rec;
    logic                         rec_we;
    logic                         link_we;
    logic [PW-1:0]                link_waddr;
    logic [PW:0]                  link_wdata;
    logic                         head_we;
    logic                         tail_we;
    logic                         fill_inc;
    logic                         bkt_inc;
    logic                         cur_from_head;
    logic                         cur_from_link;

    // effective table size: zero acts as one, clipped to the bucket count
    always_comb begin
        if (r_table_size == '0) begin
            eff_size = SW'(1);
        end else if ({4'b0, r_table_size} > 9'(MAX_BUCKETS)) begin
            eff_size = SW'(MAX_BUCKETS);
        end else begin
            eff_size = r_table_size;
        end
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_bkt = (r_bkt == BW'(eff_size - SW'(1)));
    assign head_hit = r_head_valid[r_bkt];
    assign fill_idx = r_fill[PW-1:0];

    // one restoring remainder step per cycle, msb of the id first
    assign div_bit  = r_shift[IW-1];
    assign div_part = {r_rem, div_bit};
    assign div_ge   = (div_part >= {1'b0, eff_size});
    assign div_rem  = div_ge ? SW'(div_part - {1'b0, eff_size}) : SW'(div_part);
    assign div_done = (r_cnt == CNTW'(IW - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chtbl_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_opcode == chtbl_pkg::OP_DUMP) ? chtbl_pkg::S_DMP_HEAD
                                                               : chtbl_pkg::S_DIV;
                end
            end
            chtbl_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = (r_fill == CW'(POOL_DEPTH)) ? chtbl_pkg::S_INS_OUT
                                                          : chtbl_pkg::S_INS_RD;
                end
            end
            chtbl_pkg::S_INS_RD:  n_state = chtbl_pkg::S_INS_WR1;
            chtbl_pkg::S_INS_WR1: begin
                n_state = head_hit ? chtbl_pkg::S_INS_WR2 : chtbl_pkg::S_INS_OUT;
            end
            chtbl_pkg::S_INS_WR2: n_state = chtbl_pkg::S_INS_OUT;
            chtbl_pkg::S_INS_OUT: begin
                if (out_free) n_state = chtbl_pkg::S_IDLE;
            end
            chtbl_pkg::S_DMP_HEAD: n_state = chtbl_pkg::S_DMP_CHK;
            chtbl_pkg::S_DMP_CHK: begin
                if (head_hit) begin
                    n_state = chtbl_pkg::S_DMP_REC;
                end else if (out_free) begin
                    n_state = last_bkt ? chtbl_pkg::S_IDLE : chtbl_pkg::S_DMP_HEAD;
                end
            end
            chtbl_pkg::S_DMP_REC: n_state = chtbl_pkg::S_DMP_EMIT;
            chtbl_pkg::S_DMP_EMIT: begin
                if (out_free) begin
                    if (r_link_rd[PW]) begin
                        n_state = chtbl_pkg::S_DMP_REC;
                    end else begin
                        n_state = last_bkt ? chtbl_pkg::S_IDLE : chtbl_pkg::S_DMP_HEAD;
                    end
                end
            end
            default: n_state = chtbl_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall    = (r_state != chtbl_pkg::S_IDLE);
        out_load      = 1'b0;
        out_status    = chtbl_pkg::STAT_INSERTED;
        out_last      = 1'b0;
        out_rec       = 1'b0;
        rec_we        = 1'b0;
        link_we       = 1'b0;
        link_waddr    = fill_idx;
        link_wdata    = '0;
        head_we       = 1'b0;
        tail_we       = 1'b0;
        fill_inc      = 1'b0;
        bkt_inc       = 1'b0;
        cur_from_head = 1'b0;
        cur_from_link = 1'b0;
        case (r_state)
            chtbl_pkg::S_INS_WR1: begin
                // store the record as a new chain end
                rec_we  = 1'b1;
                link_we = 1'b1;
                if (!head_hit) begin
                    head_we  = 1'b1;
                    tail_we  = 1'b1;
                    fill_inc = 1'b1;
                end
            end
            chtbl_pkg::S_INS_WR2: begin
                // append behind the old tail
                link_we    = 1'b1;
                link_waddr = r_tail_rd;
                link_wdata = {1'b1, fill_idx};
                tail_we    = 1'b1;
                fill_inc   = 1'b1;
            end
            chtbl_pkg::S_INS_OUT: begin
                out_load   = out_free;
                out_status = r_drop ? chtbl_pkg::STAT_DROPPED : chtbl_pkg::STAT_INSERTED;
                out_last   = 1'b1;
            end
            chtbl_pkg::S_DMP_CHK: begin
                if (head_hit) begin
                    cur_from_head = 1'b1;
                end else begin
                    out_load   = out_free;
                    out_status = chtbl_pkg::STAT_EMPTY;
                    out_last   = last_bkt;
                    bkt_inc    = out_free && !last_bkt;
                end
            end
            chtbl_pkg::S_DMP_EMIT: begin
                out_load      = out_free;
                out_status    = chtbl_pkg::STAT_RECORD;
                out_rec       = 1'b1;
                out_last      = last_bkt && !r_link_rd[PW];
                cur_from_link = out_free && r_link_rd[PW];
                bkt_inc       = out_free && !r_link_rd[PW] && !last_bkt;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= chtbl_pkg::S_IDLE;
            r_table_size <= chtbl_pkg::TABLE_SIZE_RST;
            r_head_valid <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_table_size <= i_cfg_data;
            if (head_we) r_head_valid[r_bkt] <= 1'b1;
            if (fill_inc) r_fill <= r_fill + CW'(1);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, remainder unit and walk pointers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id    <= i_rec_id;
            r_name  <= i_rec_name;
            r_order <= i_rec_order;
            r_shift <= i_rec_id;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_bkt   <= '0;
        end
        if (r_state == chtbl_pkg::S_DIV) begin
            r_shift <= r_shift << 1;
            r_rem   <= div_rem;
            r_cnt   <= r_cnt + CNTW'(1);
            if (div_done) begin
                r_bkt  <= BW'(div_rem);
                r_drop <= (r_fill == CW'(POOL_DEPTH));
            end
        end
        if (bkt_inc) r_bkt <= r_bkt + BW'(1);
        if (cur_from_head) r_cur <= r_head_rd;
        if (cur_from_link) r_cur <= r_link_rd[PW-1:0];
    end

    // bucket head and tail memories
    always_ff @(posedge i_clk) begin
        if (head_we) head_mem[r_bkt] <= fill_idx;
        if (tail_we) tail_mem[r_bkt] <= fill_idx;
        r_head_rd <= head_mem[r_bkt];
        r_tail_rd <= tail_mem[r_bkt];
    end

    // link and record memories
    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_waddr] <= link_wdata;
        if (rec_we) rec_mem[fill_idx] <= {r_id, r_name, r_order};
        r_link_rd <= link_mem[r_cur];
        r_rec_rd  <= rec_mem[r_cur];
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status  <= out_status;
            r_out_bkt <= r_bkt;
            r_last    <= out_last;
            if (out_rec) begin
                {r_out_id, r_out_name, r_out_order} <= r_rec_rd;
            end else begin
                r_out_id    <= '0;
                r_out_name  <= '0;
                r_out_order <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_bucket    = chtbl_pkg::BKT_OUT_W'(r_out_bkt);
    assign o_out_id    = r_out_id;
    assign o_out_name  = r_out_name;
    assign o_out_order = r_out_order;
    assign o_last      = r_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(POOL_DEPTH))
        else $error("fill count beyond pool depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |-> (r_fill == $past(r_fill) + CW'(1)))
        else $error("fill count moved by other than one");

    a_rec_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (out_status == chtbl_pkg::STAT_RECORD)) |-> (r_fill != '0))
        else $error("record dumped from an empty pool");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (out_status == chtbl_pkg::STAT_DROPPED)) |-> (r_fill == CW'(POOL_DEPTH)))
        else $error("insert dropped with room in the pool");

endmodule

/* tb/sv/chtbl_checker.sv */
// ----------------------------------------------------------------------------
// chtbl_checker
// Watches the request, result and configuration ports of the chained hash
// table. Each accepted request is run through a local model of the buckets,
// chains and record pool. The results it produces are queued, and every
// accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module chtbl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [chtbl_pkg::SIZE_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_opcode,
    input  logic [chtbl_pkg::ID_W-1:0]        i_rec_id,
    input  logic [chtbl_pkg::NAME_W-1:0]      i_rec_name,
    input  logic [chtbl_pkg::ORD_W-1:0]       i_rec_order,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [chtbl_pkg::STAT_W-1:0]      i_status,
    input  logic [chtbl_pkg::BKT_OUT_W-1:0]   i_bucket,
    input  logic [chtbl_pkg::ID_W-1:0]        i_out_id,
    input  logic [chtbl_pkg::NAME_W-1:0]      i_out_name,
    input  logic [chtbl_pkg::ORD_W-1:0]       i_out_order,
    input  logic                              i_last,
    output int unsigned                       o_pending,
    output int unsigned                       o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUCKETS = chtbl_pkg::MAX_BUCKETS_DEF;
    localparam int POOL_SLOTS  = chtbl_pkg::POOL_DEPTH_DEF;
    localparam int SLOT_W      = $clog2(POOL_SLOTS);

    typedef struct packed {
        logic [chtbl_pkg::ID_W-1:0]   id;
        logic [chtbl_pkg::NAME_W-1:0] name;
        logic [chtbl_pkg::ORD_W-1:0]  order;
    } t_table_record;

    typedef struct packed {
        logic [chtbl_pkg::STAT_W-1:0]    status;
        logic [chtbl_pkg::BKT_OUT_W-1:0] bucket;
        t_table_record                   rec;
        logic                            last;
    } t_table_result;

    // local copy of the table
    logic [chtbl_pkg::SIZE_W-1:0] table_size;
    logic              head_valid [NUM_BUCKETS];
    logic [SLOT_W-1:0] head_slot  [NUM_BUCKETS];
    logic [SLOT_W-1:0] tail_slot  [NUM_BUCKETS];
    logic              link_valid [POOL_SLOTS];
    logic [SLOT_W-1:0] link_slot  [POOL_SLOTS];
    t_table_record     record_pool [POOL_SLOTS];
    int unsigned       fill_count;

    t_table_result     expected_results [$];
    int unsigned       mismatch_count;

    // buckets in use: zero acts as one, anything above the maximum is clamped
    function automatic int unsigned buckets_in_use();
        if (table_size == '0) return 1;
        if (table_size > NUM_BUCKETS) return NUM_BUCKETS;
        return table_size;
    endfunction

    task automatic queue_result(input logic [chtbl_pkg::STAT_W-1:0] status,
                                input int unsigned bucket,
                                input t_table_record rec, input logic last);
        t_table_result res;
        res.status = status;
        res.bucket = bucket[chtbl_pkg::BKT_OUT_W-1:0];
        res.rec    = rec;
        res.last   = last;
        expected_results.push_back(res);
    endtask

    // apply one request to the table and queue the results it yields
    task automatic predict_table(input logic op, input t_table_record rec);
        int unsigned size;
        int unsigned b;
        int unsigned cur;
        int unsigned steps;
        logic        more;
        size = buckets_in_use();
        if (op == chtbl_pkg::OP_INSERT) begin
            b = rec.id % size;
            if (fill_count >= POOL_SLOTS) begin
                queue_result(chtbl_pkg::STAT_DROPPED, b, '0, 1'b1);
            end else begin
                record_pool[fill_count] = rec;
                link_valid[fill_count]  = 1'b0;
                if (!head_valid[b]) begin
                    head_valid[b] = 1'b1;
                    head_slot[b]  = fill_count[SLOT_W-1:0];
                end else begin
                    link_valid[tail_slot[b]] = 1'b1;
                    link_slot[tail_slot[b]]  = fill_count[SLOT_W-1:0];
                end
                tail_slot[b] = fill_count[SLOT_W-1:0];
                fill_count++;
                queue_result(chtbl_pkg::STAT_INSERTED, b, '0, 1'b1);
            end
        end else begin
            for (b = 0; b < size; b++) begin
                if (!head_valid[b]) begin
                    queue_result(chtbl_pkg::STAT_EMPTY, b, '0, b == size - 1);
                end else begin
                    // walk the chain from head to tail
                    cur   = head_slot[b];
                    steps = 0;
                    do begin
                        more = link_valid[cur];
                        steps++;
                        queue_result(chtbl_pkg::STAT_RECORD, b, record_pool[cur],
                                     (b == size - 1) && !(more && steps < POOL_SLOTS));
                        cur = link_slot[cur];
                    end while (more && steps < POOL_SLOTS);
                end
            end
        end
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // compare results first, then take configuration and requests
    always @(posedge i_clk) begin : monitor
        t_table_result want;
        if (!i_rst_n) begin
            table_size     = chtbl_pkg::TABLE_SIZE_RST;
            fill_count     = 0;
            mismatch_count = 0;
            for (int i = 0; i < NUM_BUCKETS; i++) head_valid[i] = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none,", $time,
                             " actual status %0h bucket %0h id %0h", i_status, i_bucket,
                             i_out_id, " name %0h order %0h last %0b", i_out_name,
                             i_out_order, i_last);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("bucket", want.bucket, i_bucket);
                    check_field("out_id", want.rec.id, i_out_id);
                    check_field("out_name", want.rec.name, i_out_name);
                    check_field("out_order", want.rec.order, i_out_order);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_cfg_we) table_size = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                predict_table(i_opcode, {i_rec_id, i_rec_name, i_rec_order});
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives insert and dump requests into the chained hash table over several
// table sizes, with random gaps and result back-pressure, and gives the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PHASE_ITEMS   = 42;
    localparam int          SETTLE_CYCLES = 30;
    localparam int          LONG_HOLD     = 300;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [chtbl_pkg::SIZE_W-1:0]        cfg_data;
    logic                                req_valid;
    logic                                req_stall;
    logic                                req_opcode;
    logic [chtbl_pkg::ID_W-1:0]          req_id;
    logic [chtbl_pkg::NAME_W-1:0]        req_name;
    logic [chtbl_pkg::ORD_W-1:0]         req_order;
    logic                                res_valid;
    logic                                res_stall;
    logic [chtbl_pkg::STAT_W-1:0]        res_status;
    logic [chtbl_pkg::BKT_OUT_W-1:0]     res_bucket;
    logic [chtbl_pkg::ID_W-1:0]          res_id;
    logic [chtbl_pkg::NAME_W-1:0]        res_name;
    logic [chtbl_pkg::ORD_W-1:0]         res_order;
    logic                                res_last;
    int unsigned                         pending;
    int unsigned                         fail_count;

    // shared between sender and receiver
    bit                     quiet;
    bit                     long_hold;

    chained_hash_table_insert_dump_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_opcode    (req_opcode),
        .i_rec_id    (req_id),
        .i_rec_name  (req_name),
        .i_rec_order (req_order),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_status    (res_status),
        .o_bucket    (res_bucket),
        .o_out_id    (res_id),
        .o_out_name  (res_name),
        .o_out_order (res_order),
        .o_last      (res_last)
    );

    chtbl_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_opcode     (req_opcode),
        .i_rec_id     (req_id),
        .i_rec_name   (req_name),
        .i_rec_order  (req_order),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_status     (res_status),
        .i_bucket     (res_bucket),
        .i_out_id     (res_id),
        .i_out_name   (res_name),
        .i_out_order  (res_order),
        .i_last       (res_last),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned draw_idle();
        return quiet ? 0 : $urandom_range(8, 0);
    endfunction

    // offer one request and hold it until taken; valid stays high on return
    task automatic send_request(input logic op, input logic [chtbl_pkg::ID_W-1:0] id,
                                input logic [chtbl_pkg::NAME_W-1:0] name,
                                input logic [chtbl_pkg::ORD_W-1:0] ord);
        int unsigned gap;
        gap = draw_idle();
        if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_opcode = op;
        req_id     = id;
        req_name   = name;
        req_order  = ord;
        req_valid  = 1'b1;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    // table size is written only once the block has drained
    task automatic write_table_size(input logic [chtbl_pkg::SIZE_W-1:0] size);
        req_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data = size;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // random requests, half the ids small so that chains grow
    task automatic run_phase(input logic [chtbl_pkg::SIZE_W-1:0] size,
                             input int unsigned dump_pct,
                             input bit no_idle, input bit hold);
        logic op;
        write_table_size(size);
        quiet     = no_idle;
        long_hold = hold;
        repeat (PHASE_ITEMS) begin
            op = ($urandom_range(99, 0) < dump_pct) ? chtbl_pkg::OP_DUMP
                                                     : chtbl_pkg::OP_INSERT;
            send_request(op,
                         $urandom_range(1, 0) ? chtbl_pkg::ID_W'($urandom_range(63, 0))
                                              : chtbl_pkg::ID_W'($urandom_range(65535, 0)),
                         chtbl_pkg::NAME_W'($urandom_range(255, 0)),
                         chtbl_pkg::ORD_W'($urandom_range(65535, 0)));
        end
        quiet = 1'b0;
    endtask

    // result side: random stalls per result, one long hold when asked
    initial begin : result_sink
        int unsigned hold_cycles;
        res_stall = 1'b0;
        forever begin
            if (long_hold) begin
                res_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            hold_cycles = draw_idle();
            if (hold_cycles != 0) begin
                res_stall = 1'b1;
                repeat (hold_cycles) @(negedge clk);
            end
            res_stall = 1'b0;
            do @(posedge clk); while (!res_valid);
            @(negedge clk);
        end
    end

    // run limit
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        req_valid  = 1'b0;
        req_opcode = chtbl_pkg::OP_INSERT;
        req_id     = '0;
        req_name   = '0;
        req_order  = '0;
        quiet      = 1'b0;
        long_hold  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset size of ten: empty dump, field extremes, chaining in bucket 0
        send_request(chtbl_pkg::OP_DUMP, '0, '0, '0);
        send_request(chtbl_pkg::OP_INSERT, 16'd0, 8'h00, 16'h0000);
        send_request(chtbl_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_request(chtbl_pkg::OP_INSERT, 16'd10, 8'hA5, 16'h5A5A);
        send_request(chtbl_pkg::OP_INSERT, 16'd20, 8'h5A, 16'hA5A5);
        send_request(chtbl_pkg::OP_DUMP, 16'hFFFF, 8'hFF, 16'hFFFF);

        // size zero acts as one bucket; earlier records stay where placed
        write_table_size(5'd0);
        send_request(chtbl_pkg::OP_INSERT, 16'h1234, 8'h3C, 16'h0F0F);
        send_request(chtbl_pkg::OP_DUMP, '0, '0, '0);

        // size above the maximum is clamped to sixteen buckets
        write_table_size(5'd31);
        send_request(chtbl_pkg::OP_INSERT, 16'd15, 8'h01, 16'h0001);
        send_request(chtbl_pkg::OP_INSERT, 16'd31, 8'h80, 16'h8000);
        send_request(chtbl_pkg::OP_INSERT, 16'h8000, 8'h7F, 16'h7FFF);
        send_request(chtbl_pkg::OP_DUMP, '0, '0, '0);

        write_table_size(5'd16);
        send_request(chtbl_pkg::OP_INSERT, 16'hFFFF, 8'hC3, 16'h1234);
        send_request(chtbl_pkg::OP_DUMP, '0, '0, '0);

        write_table_size(5'd1);
        send_request(chtbl_pkg::OP_INSERT, 16'd7, 8'h55, 16'hAAAA);
        send_request(chtbl_pkg::OP_DUMP, '0, '0, '0);

        // random part: the pool fills early, later inserts are dropped
        run_phase(5'd5, 15, 1'b0, 1'b0);
        run_phase(5'd16, 30, 1'b0, 1'b1);
        run_phase(5'd0, 40, 1'b1, 1'b0);
        run_phase(5'd31, 35, 1'b0, 1'b0);
        run_phase(5'd1, 30, 1'b0, 1'b0);
        run_phase(chtbl_pkg::SIZE_W'($urandom_range(31, 0)), 35, 1'b0, 1'b0);
        run_phase(chtbl_pkg::SIZE_W'($urandom_range(16, 1)), 40, 1'b1, 1'b0);

        // drain
        req_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/chtbl_pkg.sv
rtl/core/chained_hash_table_insert_dump_top.sv
tb/sv/chtbl_checker.sv
tb/sv/testbench.sv
